### hdl/fscs_pkg.sv
// ----------------------------------------------------------------------------
// fscs_pkg: shared types and constants of the frame store scaler
// Field widths, action and register codes, queue entry and state types.
// ----------------------------------------------------------------------------
package fscs_pkg;

  localparam int COORD_W     = 12;
  localparam int SRC_DIM_W   = 9;
  localparam int TGT_DIM_W   = 13;
  localparam int COLOUR_W    = 32;
  localparam int ACTION_W    = 2;
  // Width of a scale numerator, coordinate times source size.
  localparam int NUM_W       = COORD_W + SRC_DIM_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 40;
  localparam int QUEUE_DEPTH = 2;

  localparam int SRC_DIM_MAX = (2 ** SRC_DIM_W) - 1;
  localparam int TGT_DIM_MAX = (2 ** TGT_DIM_W) - 1;

  localparam int DEF_MAX_SOURCE_WIDTH  = 256;
  localparam int DEF_MAX_SOURCE_HEIGHT = 256;
  localparam int DEF_MAX_TARGET_DIM    = 4096;

  localparam logic [COLOUR_W-1:0] BG_RESET = 32'h00FF_FFFF;

  localparam logic [ACTION_W-1:0] ACT_WRITE  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RESIZE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_W = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_H = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT_W = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TGT_H = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BG    = 3'd5;

  typedef enum logic [1:0] {
    K_CONST,
    K_WRITE,
    K_READ,
    K_SCALE
  } fscs_kind_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_ADDR,
    B_MEM,
    B_WAIT
  } fscs_state_e;

  // Configuration, already saturated to the supported maxima.
  typedef struct packed {
    logic [SRC_DIM_W-1:0] src_w;
    logic [SRC_DIM_W-1:0] src_h;
    logic [TGT_DIM_W-1:0] tgt_w;
    logic [TGT_DIM_W-1:0] tgt_h;
    logic                 scale;
    logic [COLOUR_W-1:0]  bg;
  } fscs_cfg_t;

  // Queue entry. For direct accesses a and b are the source column and row;
  // for a scaled read they are the two numerators to divide.
  typedef struct packed {
    fscs_kind_e          kind;
    logic                in_range;
    logic [COLOUR_W-1:0] colour;
    logic [NUM_W-1:0]    a;
    logic [NUM_W-1:0]    b;
  } fscs_cmd_t;

endpackage

### hdl/fscs_ram.sv
// ----------------------------------------------------------------------------
// fscs_ram: generic single-port RAM
// One access per cycle, write or read, with registered read data.
// ----------------------------------------------------------------------------
module fscs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/fscs_fifo.sv
// ----------------------------------------------------------------------------
// fscs_fifo: short command queue
// Register-based FIFO between the classifier and the execution side.
// ----------------------------------------------------------------------------
module fscs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### hdl/fscs_div.sv
// ----------------------------------------------------------------------------
// fscs_div: iterative restoring divider
// Produces one quotient bit per cycle. The caller guarantees that the
// quotient fits in QW bits.
// ----------------------------------------------------------------------------
module fscs_div #(
  parameter int NW = 21,
  parameter int DW = 13,
  parameter int QW = 9,
  localparam int CW = (NW > DW + QW - 1) ? NW : DW + QW - 1,
  localparam int SW = $clog2(QW + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [QW-1:0] quot_o
);

  logic [CW-1:0] rem_q, rem_d;
  logic [CW-1:0] den_q, den_d;
  logic [QW-1:0] quot_q, quot_d;
  logic [SW-1:0] steps_q, steps_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic          ge;

  assign ge = (rem_q >= den_q);

  always_comb begin
    rem_d   = rem_q;
    den_d   = den_q;
    quot_d  = quot_q;
    steps_d = steps_q;
    busy_d  = busy_q;
    done_d  = done_q;
    if (start_i) begin
      // The divisor starts aligned to the top quotient bit.
      rem_d   = CW'(dividend_i);
      den_d   = CW'(divisor_i) << (QW - 1);
      quot_d  = '0;
      steps_d = SW'(QW);
      busy_d  = 1'b1;
      done_d  = 1'b0;
    end else if (busy_q) begin
      rem_d   = ge ? rem_q - den_q : rem_q;
      den_d   = den_q >> 1;
      quot_d  = {quot_q[QW-2:0], ge};
      steps_d = steps_q - 1'b1;
      if (steps_q == SW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      steps_q <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      steps_q <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### hdl/fscs_front.sv
// ----------------------------------------------------------------------------
// fscs_front: input classifier
// Decides what each accepted transaction needs and forms its queue entry.
// ----------------------------------------------------------------------------
module fscs_front
  import fscs_pkg::*;
(
  input  fscs_cfg_t             cfg_i,
  input  logic                  valid_i,
  input  logic [ACTION_W-1:0]   action_i,
  input  logic [COORD_W-1:0]    x_i,
  input  logic [COORD_W-1:0]    y_i,
  input  logic [COLOUR_W-1:0]   colour_i,
  input  logic                  full_i,
  output logic                  ready_o,
  output logic                  push_o,
  output fscs_cmd_t             cmd_o
);

  logic             in_src;
  logic             in_tgt;
  logic             src_empty;
  logic [NUM_W-1:0] num_x;
  logic [NUM_W-1:0] num_y;

  assign ready_o = !full_i;
  assign push_o  = valid_i && !full_i;

  assign in_src    = (x_i < COORD_W'(cfg_i.src_w)) && (y_i < COORD_W'(cfg_i.src_h));
  assign in_tgt    = (TGT_DIM_W'(x_i) < cfg_i.tgt_w) && (TGT_DIM_W'(y_i) < cfg_i.tgt_h);
  assign src_empty = (cfg_i.src_w == '0) || (cfg_i.src_h == '0);
  assign num_x     = NUM_W'(x_i) * NUM_W'(cfg_i.src_w);
  assign num_y     = NUM_W'(y_i) * NUM_W'(cfg_i.src_h);

  always_comb begin
    cmd_o.kind     = K_CONST;
    cmd_o.in_range = 1'b0;
    cmd_o.colour   = '0;
    cmd_o.a        = NUM_W'(x_i);
    cmd_o.b        = NUM_W'(y_i);
    case (action_i)
      ACT_WRITE: begin
        if (in_src) begin
          cmd_o.kind     = K_WRITE;
          cmd_o.in_range = 1'b1;
          cmd_o.colour   = colour_i;
        end
      end
      ACT_READ: begin
        cmd_o.colour = cfg_i.bg;
        if (in_src) begin
          cmd_o.kind     = K_READ;
          cmd_o.in_range = 1'b1;
        end
      end
      ACT_RESIZE: begin
        cmd_o.colour = cfg_i.bg;
        if (in_tgt) begin
          cmd_o.in_range = 1'b1;
          if (!cfg_i.scale) begin
            if (in_src) begin
              cmd_o.kind = K_READ;
            end
          end else if (!src_empty) begin
            // The scaled coordinate always lands inside the source.
            cmd_o.kind = K_SCALE;
            cmd_o.a    = num_x;
            cmd_o.b    = num_y;
          end
        end
      end
      default: begin
        cmd_o.kind = K_CONST;
      end
    endcase
  end

endmodule

### hdl/fscs_back.sv
// ----------------------------------------------------------------------------
// fscs_back: command execution
// Runs the two coordinate dividers, forms the store address, accesses the
// pixel store and holds the result for the output stream.
// ----------------------------------------------------------------------------
module fscs_back
  import fscs_pkg::*;
#(
  parameter int MAX_SOURCE_WIDTH  = DEF_MAX_SOURCE_WIDTH,
  parameter int MAX_SOURCE_HEIGHT = DEF_MAX_SOURCE_HEIGHT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fscs_cfg_t           cfg_i,
  input  logic                head_valid_i,
  input  fscs_cmd_t           head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [COLOUR_W-1:0] out_colour_o,
  output logic                out_in_range_o
);

  localparam int STORE_DEPTH = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
  localparam int AW   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int XW   = (MAX_SOURCE_WIDTH > 1) ? $clog2(MAX_SOURCE_WIDTH) : 1;
  localparam int YW   = (MAX_SOURCE_HEIGHT > 1) ? $clog2(MAX_SOURCE_HEIGHT) : 1;
  localparam int MW   = YW + SRC_DIM_W;
  localparam int SUMW = ((MW > AW) ? MW : AW) + 1;

  fscs_state_e state_q, state_d;
  fscs_kind_e  kind_q, kind_d;

  logic [XW-1:0]       x_q, x_d;
  logic [YW-1:0]       y_q, y_d;
  logic [COLOUR_W-1:0] colour_q, colour_d;
  logic [AW-1:0]       addr_q;
  logic [MW-1:0]       row_base;
  logic [SUMW-1:0]     addr_sum;

  logic                out_valid_q, out_valid_d;
  logic [COLOUR_W-1:0] out_colour_q, out_colour_d;
  logic                out_in_range_q, out_in_range_d;
  logic                out_free;

  logic                div_start;
  logic                dx_done, dy_done;
  logic [SRC_DIM_W-1:0] qx, qy;

  logic                ram_we, ram_re;
  logic [COLOUR_W-1:0] ram_rdata;

  assign out_free = !out_valid_q || out_ready_i;
  assign row_base = MW'(y_q) * MW'(cfg_i.src_w);
  assign addr_sum = SUMW'(row_base) + SUMW'(x_q);

  fscs_div #(
    .NW(NUM_W),
    .DW(TGT_DIM_W),
    .QW(SRC_DIM_W)
  ) u_div_x (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(head_i.a),
    .divisor_i (cfg_i.tgt_w),
    .done_o    (dx_done),
    .quot_o    (qx)
  );

  fscs_div #(
    .NW(NUM_W),
    .DW(TGT_DIM_W),
    .QW(SRC_DIM_W)
  ) u_div_y (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(head_i.b),
    .divisor_i (cfg_i.tgt_h),
    .done_o    (dy_done),
    .quot_o    (qy)
  );

  fscs_ram #(
    .WIDTH(COLOUR_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (addr_q),
    .wdata_i(colour_q),
    .rdata_o(ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (head_valid_i && out_free) begin
          case (head_i.kind)
            K_SCALE: state_d = B_DIV;
            K_READ:  state_d = B_ADDR;
            K_WRITE: state_d = B_ADDR;
            default: state_d = B_IDLE;
          endcase
        end
      end
      B_DIV: begin
        if (dx_done && dy_done) begin
          state_d = B_ADDR;
        end
      end
      B_ADDR:  state_d = B_MEM;
      B_MEM:   state_d = (kind_q == K_WRITE) ? B_IDLE : B_WAIT;
      B_WAIT:  state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    pop_o          = 1'b0;
    div_start      = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    kind_d         = kind_q;
    x_d            = x_q;
    y_d            = y_q;
    colour_d       = colour_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    out_colour_d   = out_colour_q;
    out_in_range_d = out_in_range_q;
    case (state_q)
      B_IDLE: begin
        if (head_valid_i && out_free) begin
          pop_o     = 1'b1;
          div_start = (head_i.kind == K_SCALE);
          kind_d    = head_i.kind;
          x_d       = XW'(head_i.a);
          y_d       = YW'(head_i.b);
          colour_d  = head_i.colour;
          if (head_i.kind == K_CONST) begin
            out_valid_d    = 1'b1;
            out_colour_d   = head_i.colour;
            out_in_range_d = head_i.in_range;
          end
        end
      end
      B_DIV: begin
        if (dx_done && dy_done) begin
          x_d = XW'(qx);
          y_d = YW'(qy);
        end
      end
      B_MEM: begin
        if (kind_q == K_WRITE) begin
          ram_we         = 1'b1;
          out_valid_d    = 1'b1;
          out_colour_d   = '0;
          out_in_range_d = 1'b1;
        end else begin
          ram_re = 1'b1;
        end
      end
      B_WAIT: begin
        out_valid_d    = 1'b1;
        out_colour_d   = ram_rdata;
        out_in_range_d = 1'b1;
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      kind_q      <= K_CONST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q            <= x_d;
    y_q            <= y_d;
    colour_q       <= colour_d;
    addr_q         <= addr_sum[AW-1:0];
    out_colour_q   <= out_colour_d;
    out_in_range_q <= out_in_range_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_colour_o   = out_colour_q;
  assign out_in_range_o = out_in_range_q;

  // While an item is being worked on, the output register stays empty.
  a_busy_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != B_IDLE |-> !out_valid_q)
    else $error("output register occupied while an item is in progress");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == B_IDLE && head_valid_i && out_free)
    else $error("queue popped outside the idle state or with output busy");

  a_scale_divides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> state_q == B_DIV && !dx_done && !dy_done)
    else $error("scaled read did not enter the divide phase");

  a_read_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |=> state_q == B_WAIT && !out_valid_q)
    else $error("store read not followed by the data cycle");

endmodule

### hdl/frame_store_crop_nearest_scale.sv
// ----------------------------------------------------------------------------
// frame_store_crop_nearest_scale: frame store with crop and scaled read-out
// Stores a source image and answers writes, reads and resized reads.
//
//   Port group   Direction  Contents
//   cfg_*        in         register write: enable, index, data
//   s_axis_*     in         one command per transaction
//   m_axis_*     out        one result per command
//
// A result is registered straight from the idle state when no store access
// is needed; a write passes through the address and memory states, a direct
// read adds a wait state for the store data, and a scaled read first sits in
// the divide state, where the two 9-step coordinate dividers run side by
// side. The execution side handles one command at a time and starts it only
// once the output register is free or being emptied; a two-entry queue lets
// new commands be taken while it works or while a result waits. After reset
// the pixel store content is unknown until written; configuration comes up
// as source 0x0, target 1x1, crop mode, background 0xFFFFFF.
// ----------------------------------------------------------------------------
module frame_store_crop_nearest_scale
  import fscs_pkg::*;
#(
  parameter int MAX_SOURCE_WIDTH  = DEF_MAX_SOURCE_WIDTH,
  parameter int MAX_SOURCE_HEIGHT = DEF_MAX_SOURCE_HEIGHT,
  parameter int MAX_TARGET_DIM    = DEF_MAX_TARGET_DIM
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // action[1:0], x[13:2], y[25:14], colour[57:26], zero[63:58]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // pixel_colour[31:0], in_range[32], zero[39:33]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam logic [SRC_DIM_W-1:0] SRC_W_CAP = SRC_DIM_W'(
    (MAX_SOURCE_WIDTH > SRC_DIM_MAX) ? SRC_DIM_MAX : MAX_SOURCE_WIDTH);
  localparam logic [SRC_DIM_W-1:0] SRC_H_CAP = SRC_DIM_W'(
    (MAX_SOURCE_HEIGHT > SRC_DIM_MAX) ? SRC_DIM_MAX : MAX_SOURCE_HEIGHT);
  localparam logic [TGT_DIM_W-1:0] TGT_CAP = TGT_DIM_W'(
    (MAX_TARGET_DIM > TGT_DIM_MAX) ? TGT_DIM_MAX : MAX_TARGET_DIM);

  fscs_cfg_t cfg_q, cfg_d;

  logic [SRC_DIM_W-1:0] wr_src;
  logic [TGT_DIM_W-1:0] wr_tgt;

  fscs_cmd_t           push_cmd, head_cmd;
  logic                push, pop, full, empty;
  logic [COLOUR_W-1:0] out_colour;
  logic                out_in_range;

  // Sizes are stored already saturated to the supported maxima.
  assign wr_src = cfg_wdata_i[SRC_DIM_W-1:0];
  assign wr_tgt = cfg_wdata_i[TGT_DIM_W-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SRC_W: cfg_d.src_w = (wr_src > SRC_W_CAP) ? SRC_W_CAP : wr_src;
        CFG_SRC_H: cfg_d.src_h = (wr_src > SRC_H_CAP) ? SRC_H_CAP : wr_src;
        CFG_TGT_W: cfg_d.tgt_w = (wr_tgt > TGT_CAP) ? TGT_CAP : wr_tgt;
        CFG_TGT_H: cfg_d.tgt_h = (wr_tgt > TGT_CAP) ? TGT_CAP : wr_tgt;
        CFG_MODE:  cfg_d.scale = cfg_wdata_i[0];
        CFG_BG:    cfg_d.bg    = cfg_wdata_i[COLOUR_W-1:0];
        default:   cfg_d       = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_w <= '0;
      cfg_q.src_h <= '0;
      cfg_q.tgt_w <= TGT_DIM_W'(1);
      cfg_q.tgt_h <= TGT_DIM_W'(1);
      cfg_q.scale <= 1'b0;
      cfg_q.bg    <= BG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  fscs_front u_front (
    .cfg_i   (cfg_q),
    .valid_i (s_axis_tvalid),
    .action_i(s_axis_tdata[ACTION_W-1:0]),
    .x_i     (s_axis_tdata[ACTION_W +: COORD_W]),
    .y_i     (s_axis_tdata[ACTION_W + COORD_W +: COORD_W]),
    .colour_i(s_axis_tdata[ACTION_W + 2 * COORD_W +: COLOUR_W]),
    .full_i  (full),
    .ready_o (s_axis_tready),
    .push_o  (push),
    .cmd_o   (push_cmd)
  );

  fscs_fifo #(
    .WIDTH($bits(fscs_cmd_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_cmd),
    .pop_i  (pop),
    .data_o (head_cmd),
    .full_o (full),
    .empty_o(empty)
  );

  fscs_back #(
    .MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH),
    .MAX_SOURCE_HEIGHT(MAX_SOURCE_HEIGHT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .head_valid_i  (!empty),
    .head_i        (head_cmd),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_colour_o  (out_colour),
    .out_in_range_o(out_in_range)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - COLOUR_W - 1){1'b0}}, out_in_range, out_colour};

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for frame_store_crop_nearest_scale
// Drives writes, source reads and resized reads under several register
// settings with random gaps on both streams. A shadow frame store and
// register set predict every result, and each result is compared with the
// oldest prediction in order.
// ----------------------------------------------------------------------------
module testbench;
  import fscs_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int STORE_WORDS = DEF_MAX_SOURCE_WIDTH * DEF_MAX_SOURCE_HEIGHT;
  localparam int MAX_COORD = (2 ** COORD_W) - 1;

  typedef struct packed {
    logic [COLOUR_W-1:0] colour;
    logic                in_range;
  } pixel_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Shadow copy of the block's registers and pixel store.
  logic [SRC_DIM_W-1:0] shadow_src_w = '0;
  logic [SRC_DIM_W-1:0] shadow_src_h = '0;
  logic [TGT_DIM_W-1:0] shadow_tgt_w = 1;
  logic [TGT_DIM_W-1:0] shadow_tgt_h = 1;
  logic                 shadow_scale = 1'b0;
  logic [COLOUR_W-1:0]  shadow_bg = BG_RESET;
  logic [COLOUR_W-1:0]  frame_mem [0:STORE_WORDS-1];
  bit                   frame_written [0:STORE_WORDS-1];

  pixel_result_t pending_pixels [$];
  pixel_result_t oldest_pixel;
  int error_count = 0;
  int rx_hold_cycles = 0;
  bit no_idle = 1'b0;

  frame_store_crop_nearest_scale dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned lim);
    return (v > lim) ? lim : v;
  endfunction

  // Finds the store word an access reads; returns 0 when it reads none.
  function automatic bit locate_source(input logic [ACTION_W-1:0] act,
                                       input logic [COORD_W-1:0] x, y,
                                       output int unsigned addr);
    int unsigned sw, sh, tw, th, sx, sy;
    sw = clamp_dim(shadow_src_w, DEF_MAX_SOURCE_WIDTH);
    sh = clamp_dim(shadow_src_h, DEF_MAX_SOURCE_HEIGHT);
    tw = clamp_dim(shadow_tgt_w, DEF_MAX_TARGET_DIM);
    th = clamp_dim(shadow_tgt_h, DEF_MAX_TARGET_DIM);
    sx = x;
    sy = y;
    addr = 0;
    if (act == ACT_RESIZE) begin
      if (x >= tw || y >= th) return 0;
      if (shadow_scale) begin
        if (sw == 0 || sh == 0) return 0;
        sx = (x * sw) / tw;
        sy = (y * sh) / th;
      end
    end else if (act != ACT_READ) begin
      return 0;
    end
    if (sx >= sw || sy >= sh) return 0;
    addr = sy * sw + sx;
    return 1;
  endfunction

  function automatic pixel_result_t predict_pixel(input logic [ACTION_W-1:0] act,
                                                  input logic [COORD_W-1:0] x, y,
                                                  input logic [COLOUR_W-1:0] colour);
    pixel_result_t r;
    int unsigned addr, sw, sh, tw, th;
    bit hit;
    sw = clamp_dim(shadow_src_w, DEF_MAX_SOURCE_WIDTH);
    sh = clamp_dim(shadow_src_h, DEF_MAX_SOURCE_HEIGHT);
    tw = clamp_dim(shadow_tgt_w, DEF_MAX_TARGET_DIM);
    th = clamp_dim(shadow_tgt_h, DEF_MAX_TARGET_DIM);
    r.colour = '0;
    r.in_range = 1'b0;
    case (act)
      ACT_WRITE: begin
        if (x < sw && y < sh) begin
          addr = y * sw + x;
          frame_mem[addr] = colour;
          frame_written[addr] = 1'b1;
          r.in_range = 1'b1;
        end
      end
      ACT_READ, ACT_RESIZE: begin
        if (act == ACT_READ) r.in_range = (x < sw && y < sh);
        else r.in_range = (x < tw && y < th);
        hit = locate_source(act, x, y, addr);
        r.colour = hit ? frame_mem[addr] : shadow_bg;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [COLOUR_W-1:0] got,
                                 input logic [COLOUR_W-1:0] want);
    $display("%0t mismatch in %s: got %h, expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  // One transaction on the input stream; the prediction is queued as it is offered.
  task automatic send_item(input logic [ACTION_W-1:0] act, input logic [COORD_W-1:0] x, y,
                           input logic [COLOUR_W-1:0] colour);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < 21) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata <= {6'b0, colour, y, x, act};
    s_axis_tvalid <= 1'b1;
    pending_pixels.push_back(predict_pixel(act, x, y, colour));
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // A read of a store word never written is not allowed, so such a word is
  // filled with a random colour first.
  task automatic send_action(input logic [ACTION_W-1:0] act, input logic [COORD_W-1:0] x, y,
                             input logic [COLOUR_W-1:0] colour);
    int unsigned addr, sw;
    sw = clamp_dim(shadow_src_w, DEF_MAX_SOURCE_WIDTH);
    if (locate_source(act, x, y, addr) && !frame_written[addr])
      send_item(ACT_WRITE, COORD_W'(addr % sw), COORD_W'(addr / sw), $urandom);
    send_item(act, x, y, colour);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    case (idx)
      CFG_SRC_W: shadow_src_w = value[SRC_DIM_W-1:0];
      CFG_SRC_H: shadow_src_h = value[SRC_DIM_W-1:0];
      CFG_TGT_W: shadow_tgt_w = value[TGT_DIM_W-1:0];
      CFG_TGT_H: shadow_tgt_h = value[TGT_DIM_W-1:0];
      CFG_MODE:  shadow_scale = value[0];
      CFG_BG:    shadow_bg = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_geometry(input int unsigned sw, sh, tw, th, input bit scale);
    set_register(CFG_SRC_W, sw);
    set_register(CFG_SRC_H, sh);
    set_register(CFG_TGT_W, tw);
    set_register(CFG_TGT_H, th);
    set_register(CFG_MODE, CFG_DATA_W'(scale));
  endtask

  task automatic random_items(input int n);
    logic [ACTION_W-1:0] act;
    int unsigned lim, pick, xv, yv;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(19);
      if (pick == 0) act = ACT_UNUSED;
      else if (pick <= 6) act = ACT_WRITE;
      else if (pick <= 11) act = ACT_READ;
      else act = ACT_RESIZE;
      // Mostly coordinates near the addressed image, sometimes anywhere.
      if (act == ACT_RESIZE) lim = clamp_dim(shadow_tgt_w, DEF_MAX_TARGET_DIM) + 2;
      else lim = clamp_dim(shadow_src_w, DEF_MAX_SOURCE_WIDTH) + 2;
      xv = ($urandom_range(9) == 0) ? $urandom_range(MAX_COORD)
                                    : $urandom_range(clamp_dim(lim, MAX_COORD));
      if (act == ACT_RESIZE) lim = clamp_dim(shadow_tgt_h, DEF_MAX_TARGET_DIM) + 2;
      else lim = clamp_dim(shadow_src_h, DEF_MAX_SOURCE_HEIGHT) + 2;
      yv = ($urandom_range(9) == 0) ? $urandom_range(MAX_COORD)
                                    : $urandom_range(clamp_dim(lim, MAX_COORD));
      send_action(act, COORD_W'(xv), COORD_W'(yv), $urandom);
    end
  endtask

  task automatic test_reset_state();
    send_action(ACT_READ, 0, 0, 0);
    send_action(ACT_RESIZE, 0, 0, 0);
    send_action(ACT_RESIZE, 1, 0, 0);
    send_action(ACT_WRITE, 0, 0, 32'hDEAD_BEEF);
    send_action(ACT_UNUSED, MAX_COORD, MAX_COORD, 32'hFFFF_FFFF);
  endtask

  task automatic test_edge_cases();
    wait_drained();
    // Oversized target width saturates to the maximum.
    set_geometry(256, 256, TGT_DIM_MAX, DEF_MAX_TARGET_DIM, 1'b0);
    set_register(CFG_BG, 32'h0);
    send_action(ACT_WRITE, 255, 255, 32'hFFFF_FFFF);
    send_action(ACT_WRITE, 0, 0, 32'h0);
    send_action(ACT_WRITE, 256, 0, 32'h1234_5678);
    send_action(ACT_WRITE, MAX_COORD, MAX_COORD, 32'h1234_5678);
    send_action(ACT_READ, 255, 255, 0);
    send_action(ACT_READ, 0, 0, 0);
    send_action(ACT_READ, 0, 256, 0);
    send_action(ACT_RESIZE, MAX_COORD, MAX_COORD, 0);
    send_action(ACT_RESIZE, 255, 255, 0);
    send_action(ACT_UNUSED, 0, 0, 0);
    wait_drained();
    set_register(CFG_MODE, 1);
    set_register(CFG_SRC_W, SRC_DIM_MAX);
    set_register(CFG_BG, 32'hFFFF_FFFF);
    send_action(ACT_RESIZE, MAX_COORD, MAX_COORD, 0);
    send_action(ACT_RESIZE, 0, 0, 0);
    send_action(ACT_RESIZE, MAX_COORD, 0, 0);
    wait_drained();
    set_register(CFG_TGT_W, 0);
    send_action(ACT_RESIZE, 0, 0, 0);
    wait_drained();
    // Empty source: scaled reads inside the target give the background.
    set_register(CFG_SRC_H, 0);
    set_register(CFG_TGT_W, DEF_MAX_TARGET_DIM);
    send_action(ACT_RESIZE, 5, 5, 0);
    send_action(ACT_READ, 5, 0, 0);
  endtask

  task automatic test_full_rate();
    wait_drained();
    set_geometry(8, 8, 16, 12, 1'b1);
    no_idle = 1'b1;
    random_items(150);
    wait_drained();
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    wait_drained();
    set_geometry(4, 4, 4, 4, 1'b0);
    rx_hold_cycles = 300;
    random_items(20);
    wait_drained();
    random_items(20);
  endtask

  task automatic test_random_settings();
    int unsigned pick;
    int unsigned dims [4];
    for (int phase = 0; phase < 9; phase++) begin
      wait_drained();
      for (int d = 0; d < 4; d++) begin
        pick = $urandom_range(19);
        if (d < 2) begin
          if (pick == 0) dims[d] = 0;
          else if (pick == 1) dims[d] = DEF_MAX_SOURCE_WIDTH;
          else if (pick == 2) dims[d] = $urandom_range(257, SRC_DIM_MAX);
          else dims[d] = $urandom_range(1, 24);
        end else begin
          if (pick == 0) dims[d] = 0;
          else if (pick == 1) dims[d] = DEF_MAX_TARGET_DIM;
          else if (pick == 2) dims[d] = $urandom_range(DEF_MAX_TARGET_DIM + 1, TGT_DIM_MAX);
          else if (pick == 3) dims[d] = $urandom_range(1, DEF_MAX_TARGET_DIM - 1);
          else dims[d] = $urandom_range(1, 48);
        end
      end
      set_geometry(dims[0], dims[1], dims[2], dims[3], 1'($urandom_range(1)));
      set_register(CFG_BG, $urandom);
      random_items(150);
    end
  endtask

  always @(negedge clk_i) begin
    if (rx_hold_cycles > 0) begin
      rx_hold_cycles--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(99) >= 21);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[COLOUR_W-1:0], '0);
      end else begin
        oldest_pixel = pending_pixels.pop_front();
        if (m_axis_tdata[COLOUR_W-1:0] !== oldest_pixel.colour)
          report_mismatch("pixel_colour", m_axis_tdata[COLOUR_W-1:0], oldest_pixel.colour);
        if (m_axis_tdata[COLOUR_W] !== oldest_pixel.in_range)
          report_mismatch("in_range", m_axis_tdata[COLOUR_W], oldest_pixel.in_range);
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_state();
    test_edge_cases();
    test_full_rate();
    test_backpressure();
    test_random_settings();
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/fscs_pkg.sv
hdl/fscs_ram.sv
hdl/fscs_fifo.sv
hdl/fscs_div.sv
hdl/fscs_front.sv
hdl/fscs_back.sv
hdl/frame_store_crop_nearest_scale.sv
sim/testbench.sv
